// File: rtl/assert_macros.svh
// Assertion macros shared by the oxygen analyzer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/oxa_pkg.sv
// Package with shared types and constants of the oxygen analyzer controller.
package oxa_pkg;
  localparam int unsigned AvgW = 26;
  localparam int unsigned ProdW = 40;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [1:0] ITEM_TICK = 2'd0;
  localparam logic [1:0] ITEM_SAMPLE = 2'd1;
  localparam logic [1:0] ITEM_EDGE = 2'd2;
  localparam logic [1:0] ITEM_UNUSED = 2'd3;

  localparam logic [1:0] PMODE_ANALYZING = 2'd0;
  localparam logic [1:0] PMODE_HELD = 2'd1;
  localparam logic [1:0] PMODE_CAL = 2'd2;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_SHORT = 2'd1;
  localparam logic [1:0] PUSH_LONG = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SHORT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WEIGHT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REF = 3'd4;

  typedef struct packed {
    logic start;    // latch item
    logic update;   // run the item update
    logic div_go;   // start the oxygen quotient
    logic finish;   // apply the controller step
  } oxa_cmd_t;

  typedef struct packed {
    logic div_busy;
  } oxa_sts_t;
endpackage

// File: rtl/oxygen_analyzer_controller.sv
// Top level of the oxygen analyzer controller.
//
//  Channel | Direction | Payload
//  in_     | slave     | tdata {sample, button_level}, tuser mode
//  out_    | master    | tdata {push, power, level, oxygen}, tuser program_mode
//  cfg_    | write     | cfg_index selects one of five registers
//
// Each item passes from acceptance to a valid result through item update,
// product, divider load, the 40-step restoring divider, then the controller step.
// One item is in work at a time, and its result waits in the output register
// until taken. The next item is accepted in the cycle after that transaction at the
// earliest. Reset is synchronous and active low and needs no sweep.
module oxygen_analyzer_controller
  import oxa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,  // button_level[0], sample[10:1], zeros
  input  logic [1:0]          in_tuser,  // mode[1:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata, // oxygen[15:0], level[25:16], power[26], push[28:27]
  output logic [1:0]          out_tuser, // program_mode[1:0]
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  oxa_cmd_t cmd;
  oxa_sts_t sts;
  logic [1:0] rmode, rpush;
  logic [15:0] rox;
  logic [9:0] rlev;
  logic rpow;

  // The sequencer owns the handshakes; the datapath holds all item state.
  oxa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .sts(sts)
  );

  oxa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .item_mode(in_tuser),
    .item_level(in_tdata[0]), .item_sample(in_tdata[10:1]),
    .res_mode(rmode), .res_oxygen(rox), .res_level(rlev), .res_power(rpow),
    .res_push(rpush)
  );

  // Result fields stay stable until the next item starts, after the transaction.
  assign out_tdata = {3'd0, rpush, rpow, rlev, rox};
  assign out_tuser = rmode;
endmodule

// File: rtl/oxa_ctrl.sv
// Sequencer of the oxygen analyzer: accept, item update, divide, result.
module oxa_ctrl
  import oxa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output oxa_cmd_t cmd,
  input  oxa_sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_ITEM, S_PROD, S_DIV, S_WAIT} state_t;
  state_t state_r;
  logic out_valid_r;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.start = in_valid && in_ready;
    cmd.update = (state_r == S_ITEM);
    cmd.div_go = (state_r == S_DIV);
    cmd.finish = (state_r == S_WAIT) && !sts.div_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (cmd.start) state_r <= S_ITEM;
        S_ITEM: state_r <= S_PROD;
        S_PROD: state_r <= S_DIV;
        S_DIV: state_r <= S_WAIT;
        S_WAIT: if (cmd.finish) begin
          state_r <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready, "accept while busy")
  `ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_r, "finish without result")
  `ASSERT_IMPL(a_hold_result, clk, rst_n, out_valid_r, !in_ready, "accept over pending result")
endmodule

// File: rtl/oxa_div.sv
// Restoring divider, one quotient bit per cycle.
module oxa_div
  import oxa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [ProdW-1:0] dividend,
  input  logic [AvgW-1:0]  divisor,
  output logic             busy,
  output logic [ProdW-1:0] quotient
);
  localparam int unsigned CntW = $clog2(DivSteps + 1);
  logic [CntW-1:0] cnt_r;
  logic [ProdW-1:0] q_r;
  logic [AvgW:0] rem_r;
  logic [AvgW-1:0] d_r;
  logic [AvgW:0] trial;

  assign busy = (cnt_r != '0);
  assign quotient = q_r;
  assign trial = {rem_r[AvgW-1:0], q_r[ProdW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= CntW'(DivSteps);
      q_r <= dividend;
      rem_r <= '0;
      d_r <= divisor;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
      if (trial >= {1'b0, d_r}) begin
        rem_r <= trial - {1'b0, d_r};
        q_r <= {q_r[ProdW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r <= {q_r[ProdW-2:0], 1'b0};
      end
    end
  end
endmodule

// File: rtl/oxa_dp.sv
// Datapath of the oxygen analyzer: item update, oxygen quotient, mode step.
module oxa_dp
  import oxa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  oxa_cmd_t            cmd,
  output oxa_sts_t            sts,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [1:0]          item_mode,
  input  logic                item_level,
  input  logic [9:0]          item_sample,
  output logic [1:0]          res_mode,
  output logic [15:0]         res_oxygen,
  output logic [9:0]          res_level,
  output logic                res_power,
  output logic [1:0]          res_push
);
  localparam int unsigned MulBW = AvgW + 17;
  localparam int unsigned SumW = AvgW + 1;

  logic [7:0] short_r;
  logic [9:0] long_r;
  logic [15:0] idle_lim_r, weight_r;
  logic [13:0] refc_r;
  logic [1:0] mode_r;
  logic [AvgW-1:0] avg_r, air_r;
  logic [15:0] shown_r;
  logic [9:0] ms_r;
  logic [3:0] dec_r;
  logic [16:0] idle_r;
  logic [10:0] steps_r;
  logic press_r, armed_r, power_r;
  logic [1:0] push_r, push_nxt;
  logic [1:0] imode_r;
  logic ilevel_r;
  logic [9:0] isamp_r;
  logic [ProdW-1:0] prod_r, quot;
  logic div_busy;
  logic [AvgW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [SumW-1:0] avg_sum;
  logic [16:0] inv_w;
  logic [10:0] steps_inc;

  oxa_div u_div (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .dividend(prod_r),
    .divisor(air_r), .busy(div_busy), .quotient(quot)
  );
  assign sts.div_busy = div_busy;

  assign inv_w = 17'h10000 - {1'b0, weight_r};
  // The sample term is already exact at 16 fraction bits, so only the old-average term is rounded.
  assign mul_a = AvgW'(isamp_r) * AvgW'(weight_r);
  assign mul_b = MulBW'(avg_r) * MulBW'(inv_w);
  assign avg_sum = {1'b0, mul_a} + SumW'((mul_b + MulBW'(32768)) >> 16);
  assign steps_inc = (steps_r == 11'h7FF) ? steps_r : steps_r + 11'd1;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      imode_r <= item_mode;
      ilevel_r <= item_level;
      isamp_r <= item_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= 8'd10; long_r <= 10'd150; idle_lim_r <= 16'd300;
      weight_r <= 16'd66; refc_r <= 14'd2090;
      mode_r <= PMODE_ANALYZING; avg_r <= '0; air_r <= AvgW'(6553600);
      shown_r <= '0; ms_r <= '0; dec_r <= '0; idle_r <= '0; steps_r <= '0;
      press_r <= 1'b0; armed_r <= 1'b1; power_r <= 1'b1; push_r <= PUSH_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHORT: short_r <= cfg_data[7:0];
          REG_LONG: long_r <= cfg_data[9:0];
          REG_IDLE: idle_lim_r <= cfg_data;
          REG_WEIGHT: weight_r <= cfg_data;
          REG_REF: refc_r <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        // Item update, in the cycle after acceptance.
        push_r <= PUSH_NONE;
        unique case (imode_r)
          ITEM_TICK: begin
            if (ms_r == 10'd999) begin
              ms_r <= '0;
              if (idle_r != 17'h1FFFF) idle_r <= idle_r + 17'd1;
            end else ms_r <= ms_r + 10'd1;
            dec_r <= (dec_r == 4'd9) ? 4'd0 : dec_r + 4'd1;
            if (press_r && dec_r == 4'd9) begin
              if (ilevel_r) begin
                press_r <= 1'b0;
                if (steps_r > {3'd0, short_r}) push_r <= PUSH_SHORT;
                else armed_r <= 1'b1;
              end else begin
                steps_r <= steps_inc;
                if (steps_inc > {1'b0, long_r}) begin
                  press_r <= 1'b0;
                  push_r <= PUSH_LONG;
                end
              end
            end
          end
          ITEM_SAMPLE: avg_r <= avg_sum[AvgW-1:0];
          ITEM_EDGE: if (armed_r) begin
            armed_r <= 1'b0; press_r <= 1'b1; steps_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (idle_r > {1'b0, idle_lim_r}) power_r <= 1'b0;
        if (mode_r == PMODE_CAL) begin
          if (push_r == PUSH_LONG) begin
            mode_r <= PMODE_ANALYZING; air_r <= avg_r;
          end
        end else begin
          if (mode_r == PMODE_ANALYZING)
            shown_r <= (air_r == '0) ? 16'd0 :
                       (quot > ProdW'(16'hFFFF)) ? 16'hFFFF : quot[15:0];
          if (push_r == PUSH_SHORT)
            mode_r <= (mode_r == PMODE_ANALYZING) ? PMODE_HELD : PMODE_ANALYZING;
          if (push_r == PUSH_LONG) mode_r <= PMODE_CAL;
        end
        if (push_r != PUSH_NONE) begin
          armed_r <= 1'b1; idle_r <= '0;
        end
      end
    end
  end

  // Product of the freshly updated average and reference, for the divider.
  always_ff @(posedge clk) prod_r <= ProdW'(avg_r) * ProdW'(refc_r);

  assign push_nxt = push_r;
  assign res_mode = mode_r;
  assign res_oxygen = shown_r;
  assign res_level = avg_r[AvgW-1:16];
  assign res_power = power_r;
  assign res_push = push_nxt;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_power_latched, clk, rst_n, !power_r, !power_r, "power latch released")
  `ASSERT_IMPL(a_push_code, clk, rst_n, 1'b1, push_r != 2'd3, "bad push code")
  `ASSERT_IMPL(a_phase_range, clk, rst_n, 1'b1, ms_r < 10'd1000, "millisecond phase out of range")
endmodule
